// ===== sv/binned_event_histogrammer_core_macros.svh =====
// ----------------------------------------------------------------------------
// binned event histogrammer assertion macros
// property shorthands for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef BINNED_EVENT_HISTOGRAMMER_CORE_MACROS_SVH
`define BINNED_EVENT_HISTOGRAMMER_CORE_MACROS_SVH

`ifndef SYNTH
`define BHIST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bhist assertion failed");
`define BHIST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bhist assertion failed");
`else
`define BHIST_ASSERT_IMP(label, ante, cons)
`define BHIST_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== sv/bhist_pkg.sv =====
// ----------------------------------------------------------------------------
// bhist_pkg
// transaction types, command and status types, bin edge tables and helpers
// ----------------------------------------------------------------------------
package bhist_pkg;

    localparam int EDGE_N = 17;

    localparam logic signed [15:0] PION_CODE = 16'sd211;
    localparam logic signed [15:0] PHI_HI    = 16'sd18000;
    localparam logic signed [15:0] PHI_LO    = -16'sd18000;
    localparam logic signed [16:0] PHI_OFS   = 17'sd18000;
    localparam int PHI_SPAN   = 36000;
    localparam int PHI_RSHIFT = 40;
    localparam logic [24:0] PHI_RECIP = 25'((64'd1 << PHI_RSHIFT) / PHI_SPAN);

    localparam logic [16:0] Q2_EDGES [EDGE_N] = '{
        17'd16384, 17'd19169, 17'd21791, 17'd24740, 17'd28672, 17'd34734, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536};
    localparam logic [16:0] XB_EDGES [EDGE_N] = '{
        17'd1966, 17'd3113, 17'd3768, 17'd4424, 17'd5407, 17'd9339,
        17'd9339, 17'd9339, 17'd9339, 17'd9339, 17'd9339, 17'd9339, 17'd9339,
        17'd9339, 17'd9339, 17'd9339, 17'd9339};
    localparam logic [16:0] ZH_EDGES [EDGE_N] = '{
        17'd0, 17'd16384,
        17'd16384, 17'd16384, 17'd16384, 17'd16384, 17'd16384, 17'd16384, 17'd16384,
        17'd16384, 17'd16384, 17'd16384, 17'd16384, 17'd16384, 17'd16384, 17'd16384,
        17'd16384};
    localparam logic [16:0] PT2_EDGES [EDGE_N] = '{
        17'd0, 17'd492, 17'd983, 17'd1638, 17'd2949, 17'd16384,
        17'd16384, 17'd16384, 17'd16384, 17'd16384, 17'd16384, 17'd16384, 17'd16384,
        17'd16384, 17'd16384, 17'd16384, 17'd16384};

    typedef struct packed {
        logic              req_type;
        logic              side;
        logic [3:0]        event_target;
        logic [19:0]       q2;
        logic [15:0]       xb;
        logic signed [15:0] particle_id;
        logic [15:0]       zh;
        logic [15:0]       pt2;
        logic signed [15:0] phi;
        logic [7:0]        read_kin_bin;
        logic [7:0]        read_phi_bin;
    } t_hist_req;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  kin_bin;
        logic [7:0]  phi_bin;
        logic [31:0] count;
    } t_hist_res;

    typedef struct packed {
        logic load;
        logic clr;
        logic rd;
        logic wr;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
    } t_dp_sts;

    function automatic logic in_range(input logic [19:0] v,
                                      input logic [16:0] edges [EDGE_N],
                                      input int n);
        return (v > {3'b000, edges[0]}) && (v < {3'b000, edges[n]});
    endfunction

    function automatic logic [3:0] bin_of(input logic [19:0] v,
                                          input logic [16:0] edges [EDGE_N],
                                          input int n);
        logic [3:0] b;
        b = '0;
        for (int k = 1; k < EDGE_N - 1; k++) begin
            if (k < n && v >= {3'b000, edges[k]}) begin
                b = 4'(k);
            end
        end
        return b;
    endfunction

endpackage

// ===== sv/binned_event_histogrammer_core.sv =====
// ----------------------------------------------------------------------------
// binned_event_histogrammer_core
// cut, bin and count hadron records into saturating per-bin counters
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------
// request   | start, busy          | i_req  (bhist_pkg::t_hist_req)
// result    | o_res_valid (strobe) | o_res  (bhist_pkg::t_hist_res)
// config    | i_cfg_we             | i_cfg_wdata (target_code)
//
// each transaction passes the cut and bin, index and phi product, phi
// estimate, phi correction and address stages, then a counter memory read
// and a write; busy holds off new requests and falls with the result strobe
// after reset a clear of all DEPTH addresses (27000 at defaults) zeroes both
// counter memories while busy stays high; config writes are taken throughout
// results are shown for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
`include "binned_event_histogrammer_core_macros.svh"

module binned_event_histogrammer_core #(
    parameter int N_Q2_BINS  = 6,
    parameter int N_XB_BINS  = 5,
    parameter int N_ZH_BINS  = 1,
    parameter int N_PT2_BINS = 5,
    parameter int N_PHI_BINS = 180
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bhist_pkg::t_hist_req  i_req,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_wdata,
    output logic                  o_res_valid,
    output bhist_pkg::t_hist_res  o_res
);

    bhist_pkg::t_dp_cmd cmd;
    bhist_pkg::t_dp_sts sts;

    bhist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    bhist_dp #(
        .N_Q2_BINS  (N_Q2_BINS),
        .N_XB_BINS  (N_XB_BINS),
        .N_ZH_BINS  (N_ZH_BINS),
        .N_PT2_BINS (N_PT2_BINS),
        .N_PHI_BINS (N_PHI_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    `BHIST_ASSERT_NXT(a_accept_sets_busy, start && !busy, busy)
    `BHIST_ASSERT_NXT(a_strobe_single, o_res_valid, !o_res_valid)
    `BHIST_ASSERT_IMP(a_strobe_idle, o_res_valid, !busy)
    `BHIST_ASSERT_IMP(a_fill_nonzero, o_res_valid && o_res.accepted, o_res.count != 32'd0)

endmodule

// ===== sv/bhist_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhist_ctrl
// sequencer for clearing, bin calculation and counter read-modify-write
// ----------------------------------------------------------------------------
module bhist_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    output bhist_pkg::t_dp_cmd   o_cmd,
    input  bhist_pkg::t_dp_sts   i_sts
);

    localparam logic [2:0] CALC_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_WRITE
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_CALC;
                    n_cnt   = '0;
                end
            end
            ST_CALC: begin
                if (r_cnt == CALC_LAST) begin
                    n_state = ST_READ;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_busy  <= n_busy;
        end
    end

    always_comb begin
        o_cmd.load = i_start && !r_busy;
        o_cmd.clr  = (r_state == ST_CLEAR);
        o_cmd.rd   = (r_state == ST_READ);
        o_cmd.wr   = (r_state == ST_WRITE);
    end

    assign o_busy = r_busy;

endmodule

// ===== sv/bhist_dp.sv =====
// ----------------------------------------------------------------------------
// bhist_dp
// cut and bin datapath, phi bin divider, address build and counter memories
// ----------------------------------------------------------------------------
module bhist_dp #(
    parameter int N_Q2_BINS  = 6,
    parameter int N_XB_BINS  = 5,
    parameter int N_ZH_BINS  = 1,
    parameter int N_PT2_BINS = 5,
    parameter int N_PHI_BINS = 180
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_wdata,
    input  bhist_pkg::t_hist_req  i_req,
    input  bhist_pkg::t_dp_cmd    i_cmd,
    output bhist_pkg::t_dp_sts    o_sts,
    output logic                  o_res_valid,
    output bhist_pkg::t_hist_res  o_res
);

    localparam int KIN_TOTAL = N_Q2_BINS * N_XB_BINS * N_ZH_BINS * N_PT2_BINS;
    localparam int DEPTH     = KIN_TOTAL * N_PHI_BINS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KIN_W     = $clog2(KIN_TOTAL + 1);
    localparam int PHI_BW    = $clog2(N_PHI_BINS + 1);
    localparam int PROD_W    = 16 + PHI_BW;
    localparam int MULT_W    = PROD_W + 25;
    localparam int STRIDE_Z  = N_PT2_BINS;
    localparam int STRIDE_X  = N_ZH_BINS * N_PT2_BINS;
    localparam int STRIDE_Q  = N_XB_BINS * N_ZH_BINS * N_PT2_BINS;

    logic [1:0]            r_target_code;
    bhist_pkg::t_hist_req  r_in;

    // stage 1
    logic        r_pass;
    logic        r_rd_ok;
    logic [3:0]  r_bq, r_bx, r_bz, r_bp;
    logic [15:0] r_y;
    // stage 2
    logic [KIN_W-1:0]  r_kin;
    logic [PROD_W-1:0] r_prod;
    // stage 3
    logic [PHI_BW-1:0] r_est;
    // stage 4
    logic [PHI_BW-1:0] r_pb;
    // stage 5
    logic [ADDR_W-1:0] r_addr;

    logic [31:0] r_mem_reco [DEPTH];
    logic [31:0] r_mem_thr  [DEPTH];
    logic [31:0] r_rd_reco, r_rd_thr;
    logic [ADDR_W-1:0] r_clr_addr;

    logic                r_res_valid;
    bhist_pkg::t_hist_res r_res;

    logic signed [16:0] phi_sum;
    logic [MULT_W-1:0]  est_full;
    logic [PROD_W-1:0]  rem;
    logic [PHI_BW-1:0]  pb_fix;
    logic [31:0]        cur, inc;
    logic               fill_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_code <= 2'd2;
        end else if (i_cfg_we) begin
            r_target_code <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_req;
        end
    end

    assign phi_sum = 17'(r_in.phi) + bhist_pkg::PHI_OFS;

    always_ff @(posedge i_clk) begin
        r_pass <= (r_in.event_target == {2'b00, r_target_code})
            && bhist_pkg::in_range(r_in.q2, bhist_pkg::Q2_EDGES, N_Q2_BINS)
            && bhist_pkg::in_range(20'(r_in.xb), bhist_pkg::XB_EDGES, N_XB_BINS)
            && (r_in.particle_id == bhist_pkg::PION_CODE)
            && bhist_pkg::in_range(20'(r_in.zh), bhist_pkg::ZH_EDGES, N_ZH_BINS)
            && bhist_pkg::in_range(20'(r_in.pt2), bhist_pkg::PT2_EDGES, N_PT2_BINS)
            && (r_in.phi > bhist_pkg::PHI_LO) && (r_in.phi < bhist_pkg::PHI_HI);
        r_rd_ok <= (32'(r_in.read_kin_bin) < 32'(KIN_TOTAL))
            && (32'(r_in.read_phi_bin) < 32'(N_PHI_BINS));
        r_bq <= bhist_pkg::bin_of(r_in.q2, bhist_pkg::Q2_EDGES, N_Q2_BINS);
        r_bx <= bhist_pkg::bin_of(20'(r_in.xb), bhist_pkg::XB_EDGES, N_XB_BINS);
        r_bz <= bhist_pkg::bin_of(20'(r_in.zh), bhist_pkg::ZH_EDGES, N_ZH_BINS);
        r_bp <= bhist_pkg::bin_of(20'(r_in.pt2), bhist_pkg::PT2_EDGES, N_PT2_BINS);
        r_y  <= phi_sum[15:0];
    end

    always_ff @(posedge i_clk) begin
        r_kin <= KIN_W'(r_bp) + KIN_W'(32'(r_bz) * STRIDE_Z)
            + KIN_W'(32'(r_bx) * STRIDE_X) + KIN_W'(32'(r_bq) * STRIDE_Q);
        r_prod <= PROD_W'(32'(r_y) * N_PHI_BINS);
    end

    // floor division by the phi span: reciprocal estimate, then one correction and a clamp to the last phi bin
    assign est_full = MULT_W'(r_prod) * MULT_W'(bhist_pkg::PHI_RECIP);

    always_ff @(posedge i_clk) begin
        r_est <= PHI_BW'(est_full >> bhist_pkg::PHI_RSHIFT);
    end

    assign rem = r_prod - PROD_W'(32'(r_est) * bhist_pkg::PHI_SPAN);

    always_comb begin
        pb_fix = r_est;
        if (32'(rem) >= 32'(bhist_pkg::PHI_SPAN)) begin
            pb_fix = r_est + PHI_BW'(1);
        end
        if (32'(pb_fix) >= 32'(N_PHI_BINS)) begin
            pb_fix = PHI_BW'(N_PHI_BINS - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pb <= pb_fix;
    end

    always_ff @(posedge i_clk) begin
        if (r_in.req_type) begin
            r_addr <= ADDR_W'(32'(r_in.read_kin_bin) * N_PHI_BINS)
                + ADDR_W'(r_in.read_phi_bin);
        end else begin
            r_addr <= ADDR_W'(32'(r_kin) * N_PHI_BINS) + ADDR_W'(r_pb);
        end
    end

    // clearing pass over both counter memories
    assign o_sts.clr_done = (r_clr_addr == ADDR_W'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= o_sts.clr_done ? '0 : r_clr_addr + ADDR_W'(1);
        end
    end

    assign cur     = r_in.side ? r_rd_thr : r_rd_reco;
    assign inc     = (cur == 32'hFFFF_FFFF) ? cur : cur + 32'd1;
    assign fill_wr = i_cmd.wr && !r_in.req_type && r_pass;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem_reco[r_clr_addr] <= '0;
        end else if (fill_wr && !r_in.side) begin
            r_mem_reco[r_addr] <= inc;
        end
        if (i_cmd.rd) begin
            r_rd_reco <= r_mem_reco[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem_thr[r_clr_addr] <= '0;
        end else if (fill_wr && r_in.side) begin
            r_mem_thr[r_addr] <= inc;
        end
        if (i_cmd.rd) begin
            r_rd_thr <= r_mem_thr[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            if (r_in.req_type) begin
                r_res.accepted <= 1'b0;
                r_res.kin_bin  <= r_in.read_kin_bin;
                r_res.phi_bin  <= r_in.read_phi_bin;
                r_res.count    <= r_rd_ok ? cur : 32'd0;
            end else if (r_pass) begin
                r_res.accepted <= 1'b1;
                r_res.kin_bin  <= 8'(r_kin);
                r_res.phi_bin  <= 8'(r_pb);
                r_res.count    <= inc;
            end else begin
                r_res <= '0;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
